### rtl/deht_pkg.sv
// Package for the debounced extendable heater timer.
// Widths, register indexes, reset values and the result record.
// No dependencies.
package deht_pkg;

  localparam int TIMER_BITS = 20;   // remaining-time counter width, 17..32
  localparam int GLOW_W     = 16;
  localparam int DEB_W      = 10;
  localparam int STABLE_W   = 11;
  localparam int SECS_W     = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GLOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;

  localparam logic [GLOW_W-1:0] GLOW_RESET     = 16'd10000;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 10'd100;

  localparam logic [STABLE_W-1:0] STABLE_MAX  = '1;
  localparam logic [SECS_W-1:0]   SECONDS_MAX = '1;

  // ticks -> seconds: values at or above (SECONDS_MAX+1)*1000 saturate, the rest
  // fit in 21 bits and are divided as (x >> 3) / 125 by reciprocal multiply.
  localparam int TICKS_PER_SECOND = 1000;
  localparam int DIV_IN_W   = 21;
  localparam int DIV_PRE    = 3;
  localparam int DIV_SHIFT  = 25;
  localparam int RECIP_W    = 19;
  localparam int PROD_W     = DIV_IN_W - DIV_PRE + RECIP_W;
  localparam int WIDE_BITS  = (TIMER_BITS > DIV_IN_W) ? TIMER_BITS : DIV_IN_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_SHIFT) + (TICKS_PER_SECOND >> DIV_PRE) - 1) /
             (TICKS_PER_SECOND >> DIV_PRE));
  localparam logic [WIDE_BITS-1:0] SEC_LIMIT =
    WIDE_BITS'((2 ** SECS_W) * TICKS_PER_SECOND);

  typedef struct packed {
    logic              heater_on;
    logic [SECS_W-1:0] seconds_left;
    logic              turned_on;
    logic              turned_off;
    logic              extended;
  } result_t;

endpackage

### rtl/deht_if.sv
// Handshake channel interfaces for the heater timer.
// Depends on deht_pkg for field widths.
interface deht_in_if;
  logic valid;
  logic ready;
  logic button_level;
  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface deht_out_if import deht_pkg::*;;
  logic              valid;
  logic              ready;
  logic              heater_on;
  logic [SECS_W-1:0] seconds_left;
  logic              turned_on;
  logic              turned_off;
  logic              extended;
  modport source (output valid, output heater_on, output seconds_left, output turned_on,
                  output turned_off, output extended, input ready);
  modport sink (input valid, input heater_on, input seconds_left, input turned_on,
                input turned_off, input extended, output ready);
endinterface

interface deht_cfg_if import deht_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/deht_cfg_regs.sv
// Configuration registers glow_ms and debounce_ms.
// Depends on deht_pkg.
module deht_cfg_regs import deht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] data,
  output logic [GLOW_W-1:0]     glow_ms,
  output logic [DEB_W-1:0]      debounce_ms
);

  always_ff @(posedge clk) begin
    if (rst) begin
      glow_ms     <= GLOW_RESET;
      debounce_ms <= DEBOUNCE_RESET;
    end else if (wr) begin
      unique case (index)
        REG_GLOW:     glow_ms     <= data[GLOW_W-1:0];
        REG_DEBOUNCE: debounce_ms <= data[DEB_W-1:0];
        default: ;    // unmapped index, dropped
      endcase
    end
  end

endmodule

### rtl/deht_seconds.sv
// Converts remaining ticks to whole seconds, saturating at the field maximum; zero while inactive.
// Depends on deht_pkg.
module deht_seconds import deht_pkg::*; (
  input  logic                  active,
  input  logic [TIMER_BITS-1:0] ticks,
  output logic [SECS_W-1:0]     seconds
);

  logic [WIDE_BITS-1:0]          ticks_wide;
  logic [DIV_IN_W-DIV_PRE-1:0]   eighths;
  logic [PROD_W-1:0]             prod;

  assign ticks_wide = WIDE_BITS'(ticks);
  assign eighths    = ticks_wide[DIV_IN_W-1:DIV_PRE];
  assign prod       = PROD_W'(eighths) * PROD_W'(RECIP);

  always_comb begin
    if (!active) begin
      seconds = '0;
    end else if (ticks_wide >= SEC_LIMIT) begin
      seconds = SECONDS_MAX;
    end else begin
      seconds = prod[DIV_SHIFT +: SECS_W];
    end
  end

endmodule

### rtl/deht_core.sv
// Debounce, press latch and retriggerable heater countdown.
// State advances once per tick on step; depends on deht_pkg and deht_seconds.
module deht_core import deht_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              level,
  input  logic [GLOW_W-1:0] glow_ms,
  input  logic [DEB_W-1:0]  debounce_ms,
  output result_t           res
);

  logic                  previous_level;
  logic [STABLE_W-1:0]   stable_ticks;
  logic                  press_latched;
  logic                  heater_active;
  logic [TIMER_BITS-1:0] remaining_ticks;

  logic                  previous_level_next;
  logic [STABLE_W-1:0]   stable_ticks_next;
  logic                  press_latched_next;
  logic                  heater_active_next;
  logic [TIMER_BITS-1:0] remaining_ticks_next;

  logic [TIMER_BITS-1:0] rem_dec;
  logic [TIMER_BITS:0]   ext_sum;
  logic                  level_valid;
  logic                  press;
  logic                  active_mid;
  logic                  on_pulse;
  logic                  off_pulse;
  logic                  ext_pulse;
  logic [SECS_W-1:0]     secs;

  always_comb begin
    rem_dec = (heater_active && (remaining_ticks != '0)) ?
              remaining_ticks - TIMER_BITS'(1) : remaining_ticks;

    if (level != previous_level) begin
      stable_ticks_next = '0;
    end else if (stable_ticks != STABLE_MAX) begin
      stable_ticks_next = stable_ticks + STABLE_W'(1);
    end else begin
      stable_ticks_next = stable_ticks;
    end

    level_valid = stable_ticks_next > STABLE_W'(debounce_ms);
    press       = level_valid && !level && !press_latched;

    if (press) begin
      press_latched_next = 1'b1;
    end else if (level_valid && level) begin
      press_latched_next = 1'b0;
    end else begin
      press_latched_next = press_latched;
    end

    ext_sum              = {1'b0, rem_dec} + (TIMER_BITS + 1)'(glow_ms >> 1);
    active_mid           = heater_active;
    remaining_ticks_next = rem_dec;
    on_pulse             = 1'b0;
    ext_pulse            = 1'b0;
    if (press) begin
      if (!heater_active) begin
        active_mid           = 1'b1;
        remaining_ticks_next = TIMER_BITS'(glow_ms);
        on_pulse             = 1'b1;
      end else begin
        // saturate at the counter maximum
        remaining_ticks_next = ext_sum[TIMER_BITS] ? '1 : ext_sum[TIMER_BITS-1:0];
        ext_pulse            = 1'b1;
      end
    end

    off_pulse           = active_mid && (remaining_ticks_next == '0);
    heater_active_next  = active_mid && !off_pulse;
    previous_level_next = level;
  end

  deht_seconds u_seconds (
    .active  (heater_active_next),
    .ticks   (remaining_ticks_next),
    .seconds (secs)
  );

  always_comb begin
    res.heater_on    = heater_active_next;
    res.seconds_left = secs;
    res.turned_on    = on_pulse;
    res.turned_off   = off_pulse;
    res.extended     = ext_pulse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level  <= 1'b1;
      stable_ticks    <= '0;
      press_latched   <= 1'b0;
      heater_active   <= 1'b0;
      remaining_ticks <= '0;
    end else if (step) begin
      previous_level  <= previous_level_next;
      stable_ticks    <= stable_ticks_next;
      press_latched   <= press_latched_next;
      heater_active   <= heater_active_next;
      remaining_ticks <= remaining_ticks_next;
    end
  end

endmodule

### rtl/debounced_extendable_heater_timer.sv
// Top level of the debounced extendable heater timer.
// Depends on deht_pkg, deht_if, deht_cfg_regs and deht_core.
//
// Usage:
//   in_ch  : one request per millisecond tick, carrying button_level
//            (0 pressed, 1 released).
//   out_ch : exactly one result request per tick: heater_on, seconds_left,
//            and the turned_on / turned_off / extended pulses.
//   cfg_ch : register writes, index 0 = glow_ms, 1 = debounce_ms; always ready.
//            Other indexes are dropped. Write only while the block is idle.
// Path: a tick accepted on in_ch reaches out_ch through the input register,
//   then the state update into the result register.
// Throughput: one tick per cycle while out_ch is ready; the state update and
//   seconds conversion (one 18x19 reciprocal multiply) are combinational.
// Stall: when out_ch is not ready, the result holds in the output register
//   and the input register holds its tick; in_ch.ready drops only once both
//   are full, so no tick is lost or duplicated.
// Reset: rst (sync, active high) empties both registers, restores register
//   defaults (glow 10000, debounce 100) and clears the timer state with the
//   button taken as released.
module debounced_extendable_heater_timer import deht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  deht_in_if.sink    in_ch,
  deht_out_if.source out_ch,
  deht_cfg_if.sink   cfg_ch
);

  logic       in_valid;    // input register holds a tick
  logic       in_level;
  logic       out_valid;   // result register holds a result
  result_t    out_res;
  logic       out_free;
  logic       advance;
  logic [GLOW_W-1:0] glow_ms;
  logic [DEB_W-1:0]  debounce_ms;
  result_t    core_res;

  // Result register can take a new result when empty or being drained.
  assign out_free     = !out_valid || out_ch.ready;
  assign advance      = in_valid && out_free;
  assign in_ch.ready  = !in_valid || out_free;
  assign cfg_ch.ready = 1'b1;

  deht_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr          (cfg_ch.valid),
    .index       (cfg_ch.index),
    .data        (cfg_ch.data),
    .glow_ms     (glow_ms),
    .debounce_ms (debounce_ms)
  );

  deht_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .level       (in_level),
    .glow_ms     (glow_ms),
    .debounce_ms (debounce_ms),
    .res         (core_res)
  );

  // Input register: loads whenever it is empty or handing its tick on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_level <= in_ch.button_level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.heater_on    = out_res.heater_on;
  assign out_ch.seconds_left = out_res.seconds_left;
  assign out_ch.turned_on    = out_res.turned_on;
  assign out_ch.turned_off   = out_res.turned_off;
  assign out_ch.extended     = out_res.extended;

endmodule

### rtl/deht_checker.sv
// Port-level assertions for the heater timer, attached by bind.
// Depends on deht_pkg and debounced_extendable_heater_timer.
module deht_checker import deht_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              heater_on,
  input logic [SECS_W-1:0] seconds_left,
  input logic              turned_on,
  input logic              turned_off,
  input logic              extended
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_off_no_secs: assert property (@(posedge clk) disable iff (rst)
    out_valid && !heater_on |-> seconds_left == '0)
    else $error("seconds left while heater off");

  a_on_xor_ext: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(turned_on && extended))
    else $error("start and extension in one tick");

  a_off_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && turned_off |-> !heater_on)
    else $error("turn-off pulse with heater still on");

endmodule

bind debounced_extendable_heater_timer deht_checker u_deht_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .heater_on    (out_ch.heater_on),
  .seconds_left (out_ch.seconds_left),
  .turned_on    (out_ch.turned_on),
  .turned_off   (out_ch.turned_off),
  .extended     (out_ch.extended)
);
